// ===== sv/priority_ready_queue_scheduler_defines.svh =====
// Assertion macros used by the scheduler engine.
`ifndef PRIORITY_READY_QUEUE_SCHEDULER_DEFINES_SVH
`define PRIORITY_READY_QUEUE_SCHEDULER_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during rst.
`define PRQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scheduler check failed");

// Next-cycle implication, sampled on clk and disabled during rst.
`define PRQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scheduler check failed");

`endif

// ===== sv/prq_pkg.sv =====
`timescale 1ns / 1ps
package prq_pkg;

  localparam int NUM_LEVELS = 32;
  localparam int NUM_TASKS  = 32;
  localparam int LVL_W      = $clog2(NUM_LEVELS);
  localparam int TASK_W     = $clog2(NUM_TASKS);

  typedef enum logic [1:0] {
    OP_SET   = 2'd0,
    OP_WAKE  = 2'd1,
    OP_YIELD = 2'd2,
    OP_SCHED = 2'd3
  } prq_op_t;

  typedef enum logic [1:0] {
    ST_RUN   = 2'd0,
    ST_INT   = 2'd1,
    ST_UNINT = 2'd2,
    ST_DEAD  = 2'd3
  } prq_st_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RDA,
    S_EVAL,
    S_DQ,
    S_ENQ,
    S_ENQ2,
    S_DEC,
    S_DEC2,
    S_OUT
  } prq_fsm_t;

  typedef struct packed {
    prq_op_t     op;
    logic [4:0]  task_req;
    logic [4:0]  task_prio;
    prq_st_t     new_state;
  } prq_req_t;

  typedef struct packed {
    logic [4:0]  next_task;
    logic        next_is_idle;
    logic        switched;
    logic        refused;
    logic        prev_dead;
    logic [31:0] ready_levels;
  } prq_res_t;

  // Priority encoder: lowest set level of the ready bitmap.
  function automatic logic [LVL_W-1:0] lowest_level(input logic [NUM_LEVELS-1:0] bm);
    logic [LVL_W-1:0] l;
    l = '0;
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (bm[i]) l = LVL_W'(i);
    end
    return l;
  endfunction

endpackage

// ===== sv/prq_ram.sv =====
`timescale 1ns / 1ps
module prq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/prq_engine.sv =====
`timescale 1ns / 1ps
`include "priority_ready_queue_scheduler_defines.svh"
module prq_engine (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  prq_pkg::prq_req_t req,
  output logic              req_ready,
  output logic              res_valid,
  input  logic              res_ready,
  output prq_pkg::prq_res_t res
);
  import prq_pkg::*;

  prq_fsm_t state, state_next;

  // Captured item.
  prq_op_t             op;
  logic [TASK_W-1:0]   tsk;
  logic                task_ok;
  logic [LVL_W-1:0]    lvl_in;
  prq_st_t             new_st;

  // Working registers.
  logic [LVL_W-1:0]    lv;
  logic [TASK_W-1:0]   etask;
  logic                need;
  logic [TASK_W-1:0]   cur;
  logic                cur_idle;
  logic [NUM_LEVELS-1:0] bitmap;
  logic [NUM_TASKS-1:0]  st_valid;
  logic                st_vld_q;

  logic [4:0]          r_next_task;
  logic                r_idle, r_sw, r_ref, r_dead;

  // Memory ports.
  logic st_we, lvl_we, head_we, tail_we, nx_we, pv_we;
  logic [TASK_W-1:0] st_wa, st_ra, lvl_wa, lvl_ra, nx_wa, nx_ra, pv_wa, pv_ra;
  logic [LVL_W-1:0]  head_wa, head_ra, tail_wa, tail_ra;
  logic [1:0]        st_wd, st_rd;
  logic [LVL_W-1:0]  lvl_wd, lvl_rd;
  logic [TASK_W-1:0] head_wd, head_rd, tail_wd, tail_rd;
  logic [TASK_W-1:0] nx_wd, nx_rd, pv_wd, pv_rd;

  // Decode of the first lookup.
  prq_st_t           old_st;
  logic [LVL_W-1:0]  eff_lvl, lv_c;
  logic [TASK_W-1:0] addr_a, task_c;
  logic              need_c, enq, deq, refuse, yld_go, dq_keep;
  prq_fsm_t          after_enq;

  always_comb begin
    old_st    = st_vld_q ? prq_st_t'(st_rd) : ST_INT;
    addr_a    = (op == OP_YIELD) ? cur : tsk;
    eff_lvl   = (old_st == ST_RUN) ? lvl_rd : lvl_in;
    lv_c      = (state == S_EVAL) ? ((op == OP_YIELD) ? lvl_rd : eff_lvl) : lv;
    task_c    = (state == S_EVAL) ? addr_a : etask;
    need_c    = (bitmap == '0) || (lowest_level(bitmap) >= eff_lvl);
    refuse    = (op == OP_WAKE) && (old_st == ST_UNINT);
    enq       = ((op == OP_WAKE) || (new_st == ST_RUN)) && (old_st != ST_RUN);
    deq       = (op == OP_SET) && (new_st != ST_RUN) && (old_st == ST_RUN);
    yld_go    = !cur_idle && (old_st == ST_RUN) && bitmap[lvl_rd];
    dq_keep   = (op == OP_YIELD) && (head_rd == tail_rd);
    after_enq = ((op == OP_SET) || ((op == OP_WAKE) && !need)) ? S_OUT : S_DEC;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (req_valid) state_next = S_RDA;
      S_RDA:  state_next = S_EVAL;
      S_EVAL: begin
        unique case (op)
          OP_SCHED: state_next = S_DEC;
          OP_YIELD: state_next = yld_go ? S_DQ : S_DEC;
          default: begin
            if (!task_ok || refuse)              state_next = S_OUT;
            else if (enq)                        state_next = S_ENQ;
            else if (deq && bitmap[eff_lvl])     state_next = S_DQ;
            else if ((op == OP_WAKE) && need_c)  state_next = S_DEC;
            else                                 state_next = S_OUT;
          end
        endcase
      end
      S_DQ: begin
        if (dq_keep)              state_next = S_DEC;
        else if (op == OP_YIELD)  state_next = S_ENQ;
        else                      state_next = S_OUT;
      end
      S_ENQ:  state_next = bitmap[lv] ? S_ENQ2 : after_enq;
      S_ENQ2: state_next = after_enq;
      S_DEC:  state_next = S_DEC2;
      S_DEC2: state_next = S_OUT;
      S_OUT:  if (res_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Memory addressing and write-back.
  always_comb begin
    st_we = 1'b0;   st_wa = tsk;  st_wd = 2'(ST_RUN); st_ra = addr_a;
    lvl_we = 1'b0;  lvl_wa = etask; lvl_wd = lv;      lvl_ra = addr_a;
    head_we = 1'b0; head_wa = lv; head_wd = etask;    head_ra = lv_c;
    tail_we = 1'b0; tail_wa = lv; tail_wd = etask;    tail_ra = lv_c;
    nx_we = 1'b0;   nx_wa = pv_rd; nx_wd = nx_rd;     nx_ra = task_c;
    pv_we = 1'b0;   pv_wa = nx_rd; pv_wd = pv_rd;     pv_ra = task_c;
    req_ready = (state == S_IDLE);
    res_valid = (state == S_OUT);
    unique case (state)
      S_EVAL: begin
        if (((op == OP_SET) || (op == OP_WAKE)) && task_ok && !refuse) begin
          st_we = 1'b1;
          st_wd = (op == OP_WAKE) ? 2'(ST_RUN) : 2'(new_st);
        end
      end
      S_DQ: begin
        if (!dq_keep) begin
          if ((head_rd == etask) && (tail_rd == etask)) begin
            head_we = 1'b0;
          end else if (head_rd == etask) begin
            head_we = 1'b1;
            head_wd = nx_rd;
          end else if (tail_rd == etask) begin
            tail_we = 1'b1;
            tail_wd = pv_rd;
          end else begin
            // Middle of the list: splice the neighbors together.
            nx_we = 1'b1;
            pv_we = 1'b1;
          end
        end
      end
      S_ENQ: begin
        lvl_we = 1'b1;
        if (!bitmap[lv]) begin
          head_we = 1'b1;
          tail_we = 1'b1;
        end
      end
      S_ENQ2: begin
        nx_we = 1'b1;  nx_wa = tail_rd; nx_wd = etask;
        pv_we = 1'b1;  pv_wa = etask;   pv_wd = tail_rd;
        tail_we = 1'b1;
      end
      S_DEC: begin
        head_ra = lowest_level(bitmap);
        st_ra   = cur;
      end
      default: ;
    endcase
  end

  always_comb begin
    res.next_task    = r_next_task;
    res.next_is_idle = r_idle;
    res.switched     = r_sw;
    res.refused      = r_ref;
    res.prev_dead    = r_dead;
    res.ready_levels = 32'(bitmap);
  end

  // Run state has a known reset value; unwritten entries read as interruptible.
  always_ff @(posedge clk) begin
    if (rst) st_valid <= '0;
    else if (st_we) st_valid[st_wa] <= 1'b1;
    st_vld_q <= st_valid[st_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur      <= '0;
      cur_idle <= 1'b1;
      bitmap   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            op      <= req.op;
            tsk     <= TASK_W'(req.task_req);
            task_ok <= int'(req.task_req) < NUM_TASKS;
            lvl_in  <= (int'(req.task_prio) >= NUM_LEVELS) ? LVL_W'(NUM_LEVELS - 1)
                                                           : LVL_W'(req.task_prio);
            new_st  <= req.new_state;
          end
          r_next_task <= '0;
          r_idle      <= 1'b0;
          r_sw        <= 1'b0;
          r_ref       <= 1'b0;
          r_dead      <= 1'b0;
        end
        S_EVAL: begin
          lv    <= lv_c;
          etask <= task_c;
          need  <= need_c;
          r_ref <= task_ok && refuse;
        end
        S_DQ: begin
          if (!dq_keep && (head_rd == etask) && (tail_rd == etask)) bitmap[lv] <= 1'b0;
        end
        S_ENQ: bitmap[lv] <= 1'b1;
        S_DEC2: begin
          r_sw   <= 1'b1;
          r_dead <= !cur_idle && (old_st == ST_DEAD);
          if (bitmap == '0) begin
            cur_idle <= 1'b1;
            cur      <= '0;
            r_idle   <= 1'b1;
          end else begin
            cur_idle    <= 1'b0;
            cur         <= head_rd;
            r_next_task <= 5'(head_rd);
          end
        end
        default: ;
      endcase
    end
  end

  prq_ram #(.WIDTH(2), .DEPTH(NUM_TASKS)) u_state (
    .clk(clk), .we(st_we), .waddr(st_wa), .wdata(st_wd), .raddr(st_ra), .rdata(st_rd));
  prq_ram #(.WIDTH(LVL_W), .DEPTH(NUM_TASKS)) u_level (
    .clk(clk), .we(lvl_we), .waddr(lvl_wa), .wdata(lvl_wd), .raddr(lvl_ra), .rdata(lvl_rd));
  prq_ram #(.WIDTH(TASK_W), .DEPTH(NUM_LEVELS)) u_head (
    .clk(clk), .we(head_we), .waddr(head_wa), .wdata(head_wd), .raddr(head_ra),
    .rdata(head_rd));
  prq_ram #(.WIDTH(TASK_W), .DEPTH(NUM_LEVELS)) u_tail (
    .clk(clk), .we(tail_we), .waddr(tail_wa), .wdata(tail_wd), .raddr(tail_ra),
    .rdata(tail_rd));
  prq_ram #(.WIDTH(TASK_W), .DEPTH(NUM_TASKS)) u_next (
    .clk(clk), .we(nx_we), .waddr(nx_wa), .wdata(nx_wd), .raddr(nx_ra), .rdata(nx_rd));
  prq_ram #(.WIDTH(TASK_W), .DEPTH(NUM_TASKS)) u_prev (
    .clk(clk), .we(pv_we), .waddr(pv_wa), .wdata(pv_wd), .raddr(pv_ra), .rdata(pv_rd));

  `PRQ_ASSERT_IMP(a_idle_means_empty, res_valid && res.next_is_idle, res.ready_levels == '0)
  `PRQ_ASSERT_IMP(a_refuse_no_switch, res_valid && res.refused, !res.switched)
  `PRQ_ASSERT_NEXT(a_accept_starts, req_valid && (state == S_IDLE), state == S_RDA)

endmodule

// ===== sv/priority_ready_queue_scheduler.sv =====
`timescale 1ns / 1ps
// A result beat is offered after the engine steps through S_RDA, S_EVAL, the states of
// S_DQ/S_ENQ/S_ENQ2/S_DEC/S_DEC2 its operation needs, and S_OUT; a state change without
// a switch is shortest, a yield that rotates its level is longest. One item at a time:
// the next input is taken once the last result leaves S_OUT (an output stall holds it).
// Reset: ready bitmap cleared, all tasks interruptible, idle current; lists undefined.
module priority_ready_queue_scheduler (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  op,
  input  logic [4:0]  task_req,
  input  logic [4:0]  task_prio,
  input  logic [1:0]  new_state,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  next_task,
  output logic        next_is_idle,
  output logic        switched,
  output logic        refused,
  output logic        prev_dead,
  output logic [31:0] ready_levels
);
  import prq_pkg::*;

  prq_req_t req;
  prq_res_t res, res_reg;
  logic     req_ready, res_valid, res_ready;

  assign req.op        = prq_op_t'(op);
  assign req.task_req  = task_req;
  assign req.task_prio = task_prio;
  assign req.new_state = prq_st_t'(new_state);
  assign in_stall      = !req_ready;

  // The output register frees the engine as soon as a result beat is parked here.
  assign res_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (res_valid && res_ready) res_reg <= res;
  end

  assign next_task    = res_reg.next_task;
  assign next_is_idle = res_reg.next_is_idle;
  assign switched     = res_reg.switched;
  assign refused      = res_reg.refused;
  assign prev_dead    = res_reg.prev_dead;
  assign ready_levels = res_reg.ready_levels;

  prq_engine u_engine (
    .clk(clk), .rst(rst),
    .req_valid(in_valid), .req(req), .req_ready(req_ready),
    .res_valid(res_valid), .res_ready(res_ready), .res(res));

endmodule
